// ===== rtl/mspp_pkg.sv =====
package mspp_pkg;

	// Capacity of the record store and the widths that follow from it.
	localparam int MAX_MODULES = 32;
	localparam int IDX_W = $clog2(MAX_MODULES);
	localparam int CNT_W = $clog2(MAX_MODULES + 1);

	// Page rounding mask for the bump allocator.
	localparam logic [63:0] PAGE_MASK = 64'hFFF;

	// Configuration port geometry: one 64-bit register at byte address 0.
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 64;
	localparam logic REG_HEAP_BASE = 1'b0;

	// One stored module record.
	typedef struct packed {
		logic [63:0] addr;
		logic [31:0] len;
	} rec_t;

	localparam int REC_W = $bits(rec_t);

endpackage

// ===== rtl/mspp_if.sv =====
// Input channel: one module record per item.
interface mspp_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] module_address;
	logic [31:0] module_length;
	logic        is_last;

	modport source (output valid, output module_address, output module_length,
		output is_last, input ready);
	modport sink (input valid, input module_address, input module_length,
		input is_last, output ready);
endinterface

// Output channel: one placed record per item.
interface mspp_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] old_address;
	logic [31:0] length_out;
	logic [63:0] new_address;
	logic        dropped;
	logic        last_out;

	modport source (output valid, output old_address, output length_out,
		output new_address, output dropped, output last_out, input ready);
	modport sink (input valid, input old_address, input length_out,
		input new_address, input dropped, input last_out, output ready);
endinterface

// ===== rtl/module_sort_and_page_place.sv =====
// Channel   Role    Payload
// in_ch     sink    module_address[63:0], module_length[31:0], is_last
// out_ch    source  old_address[63:0], length_out[31:0], new_address[63:0],
//                   dropped, last_out
// apb       slave   heap_base at byte address 0 (64-bit data)
//
// Each record is stored as accepted; the block stays ready until the last item.
// After the last item, the records are selection-sorted by address, limited
// by the single read port of the record RAM feeding one 64-bit comparator.
// Each result then takes a RAM read and an output capture, waiting on stalls.
// Reset is asynchronous, active low; the record RAM holds no reset state.
// A stalled output holds its item; the next batch may load once all are placed.
module module_sort_and_page_place
	import mspp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	mspp_in_if.sink            in_ch,
	mspp_out_if.source         out_ch,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RDI,
		S_CAPI,
		S_SCAN,
		S_SWAP1,
		S_SWAP2,
		S_ORD,
		S_OCAP
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               ovf_q;
	logic [CNT_W-1:0]   n_q;
	logic [CNT_W-1:0]   i_q;
	logic [CNT_W-1:0]   j_q;
	logic [CNT_W-1:0]   k_q;
	logic [CNT_W-1:0]   best_idx_q;
	rec_t               best_q;
	rec_t               reci_q;
	logic [63:0]        bump_q;
	logic               batch_ovf_q;
	logic [63:0]        heap_base_q;

	logic               out_valid_q;
	logic [63:0]        old_addr_q;
	logic [31:0]        len_q;
	logic [63:0]        new_addr_q;
	logic               dropped_q;
	logic               last_q;

	logic               in_acc;
	logic               room;
	logic [CNT_W-1:0]   cnt_next;
	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	rec_t               ram_wdata;
	logic [IDX_W-1:0]   ram_raddr;
	logic [REC_W-1:0]   ram_rdata;
	rec_t               rd_rec;
	logic [63:0]        rounded;
	logic               pass_more;

	// Configuration port.
	assign pready = 1'b1;
	assign prdata = (paddr[3] == REG_HEAP_BASE) ? heap_base_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_base_q <= '0;
		end else if (psel && penable && pwrite && (paddr[3] == REG_HEAP_BASE)) begin
			heap_base_q <= pwdata;
		end
	end

	// Handshake and load bookkeeping.
	assign in_ch.ready = (state_q == S_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign room        = (cnt_q < CNT_W'(MAX_MODULES));
	assign cnt_next    = room ? cnt_q + CNT_W'(1) : cnt_q;

	// Another sort pass follows when at least two records remain unsorted.
	assign pass_more = (i_q + CNT_W'(2)) < n_q;

	// Record RAM write port: loads, then the two halves of a swap.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_q[IDX_W-1:0];
		ram_wdata = '{addr: in_ch.module_address, len: in_ch.module_length};
		case (state_q)
			S_IDLE: begin
				ram_we = in_acc && room;
			end
			S_SWAP1: begin
				ram_we    = 1'b1;
				ram_waddr = i_q[IDX_W-1:0];
				ram_wdata = best_q;
			end
			S_SWAP2: begin
				ram_we    = 1'b1;
				ram_waddr = best_idx_q[IDX_W-1:0];
				ram_wdata = reci_q;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// Read address is set in the state before the one that consumes the data.
	always_comb begin
		case (state_q)
			S_RDI:   ram_raddr = i_q[IDX_W-1:0];
			S_CAPI:  ram_raddr = IDX_W'(i_q + CNT_W'(1));
			S_SCAN:  ram_raddr = IDX_W'(j_q + CNT_W'(1));
			S_ORD:   ram_raddr = k_q[IDX_W-1:0];
			default: ram_raddr = '0;
		endcase
	end

	mspp_ram #(
		.WIDTH (REC_W),
		.DEPTH (MAX_MODULES)
	) u_rec_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_rec  = rec_t'(ram_rdata);
	assign rounded = ({32'b0, rd_rec.len} + PAGE_MASK) & ~PAGE_MASK;

	// Sequencer: load, selection sort over the RAM, then placement.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			n_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			best_idx_q  <= '0;
			best_q      <= '0;
			reci_q      <= '0;
			bump_q      <= '0;
			batch_ovf_q <= 1'b0;
			out_valid_q <= 1'b0;
			old_addr_q  <= '0;
			len_q       <= '0;
			new_addr_q  <= '0;
			dropped_q   <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (in_ch.is_last) begin
							n_q         <= cnt_next;
							cnt_q       <= '0;
							ovf_q       <= 1'b0;
							batch_ovf_q <= ovf_q || !room;
							bump_q      <= heap_base_q;
							i_q         <= '0;
							k_q         <= '0;
							state_q     <= (cnt_next >= CNT_W'(2)) ? S_RDI : S_ORD;
						end else begin
							cnt_q <= cnt_next;
							if (!room) begin
								ovf_q <= 1'b1;
							end
						end
					end
				end
				S_RDI: begin
					state_q <= S_CAPI;
				end
				S_CAPI: begin
					reci_q     <= rd_rec;
					best_q     <= rd_rec;
					best_idx_q <= i_q;
					j_q        <= i_q + CNT_W'(1);
					state_q    <= S_SCAN;
				end
				S_SCAN: begin
					// Strictly smaller keeps the first minimum on ties.
					if (rd_rec.addr < best_q.addr) begin
						best_q     <= rd_rec;
						best_idx_q <= j_q;
					end
					if (j_q == n_q - CNT_W'(1)) begin
						state_q <= S_SWAP1;
					end else begin
						j_q <= j_q + CNT_W'(1);
					end
				end
				S_SWAP1: begin
					if (best_idx_q != i_q) begin
						state_q <= S_SWAP2;
					end else begin
						i_q     <= i_q + CNT_W'(1);
						state_q <= pass_more ? S_RDI : S_ORD;
					end
				end
				S_SWAP2: begin
					i_q     <= i_q + CNT_W'(1);
					state_q <= pass_more ? S_RDI : S_ORD;
				end
				S_ORD: begin
					// Capture only when the output register is free next cycle.
					if (!out_valid_q || out_ch.ready) begin
						state_q <= S_OCAP;
					end
				end
				S_OCAP: begin
					out_valid_q <= 1'b1;
					old_addr_q  <= rd_rec.addr;
					len_q       <= rd_rec.len;
					new_addr_q  <= bump_q;
					dropped_q   <= batch_ovf_q;
					last_q      <= (k_q == n_q - CNT_W'(1));
					bump_q      <= bump_q + rounded;
					k_q         <= k_q + CNT_W'(1);
					state_q     <= (k_q == n_q - CNT_W'(1)) ? S_IDLE : S_ORD;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output channel.
	assign out_ch.valid       = out_valid_q;
	assign out_ch.old_address = old_addr_q;
	assign out_ch.length_out  = len_q;
	assign out_ch.new_address = new_addr_q;
	assign out_ch.dropped     = dropped_q;
	assign out_ch.last_out    = last_q;

`ifndef SYNTHESIS
	// The load counter never passes the store capacity.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_MODULES))
		else $error("record count exceeds capacity");

	// The scan index stays inside the batch.
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (j_q < n_q && j_q > i_q))
		else $error("scan index outside batch");

	// A second swap write happens only when the minimum moved.
	a_swap_needed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SWAP2) |-> (best_idx_q != i_q))
		else $error("swap of a record with itself");

	// A new result appears only right after a capture.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_OCAP))
		else $error("output valid without capture");

	// Capture never overwrites a result still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OCAP) |-> !out_valid_q)
		else $error("output overwritten while pending");
`endif

endmodule

// ===== rtl/mspp_ram.sv =====
// Simple dual-port RAM: one write port, one read port with registered data.
module mspp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
